// ===== hdl/vto_pkg.sv =====
// Shared types, constants and character helpers for the version token obfuscator.
`default_nettype none

package vto_pkg;

  localparam int KEY_LEN    = 12;  // fixed key bytes in use, 1..12
  localparam int KEY_BYTES  = 12;
  localparam int VER_BYTES  = 16;
  localparam int HEX_LEN    = 8;
  localparam int TS_BYTES   = 4;
  localparam int TOKEN_RAW  = 20;
  localparam int TOKEN_B64  = 28;
  localparam int B64_GROUPS = TOKEN_RAW / 3;  // complete 3-byte groups
  localparam int POS_W      = $clog2(TOKEN_B64);
  localparam int GRP_W      = POS_W - 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] B64_PAD = 8'h3d;  // '='

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    KIND_B64 = 2'd0,
    KIND_RAW = 2'd1,
    KIND_WIN = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERSION_LOW  = 3'd0,
    REG_VERSION_HIGH = 3'd1,
    REG_KEY_LOW      = 3'd2,
    REG_KEY_HIGH     = 3'd3,
    REG_WINVER_WORD0 = 3'd4,
    REG_WINVER_WORD1 = 3'd5,
    REG_WINVER_WORD2 = 3'd6
  } reg_idx_e;

  // One finished raw token plus how it is to be sent.
  typedef struct packed {
    logic                        b64;
    logic [TOKEN_RAW-1:0][7:0]   raw;
  } token_t;

  function automatic byte_t hex_char(input logic [3:0] nib);
    byte_t c;
    if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
    else             c = 8'h57 + {4'h0, nib};  // 'a' - 10
    return c;
  endfunction

  function automatic byte_t b64_char(input logic [5:0] v);
    byte_t c;
    if (v < 6'd26)       c = 8'h41 + {2'b00, v};
    else if (v < 6'd52)  c = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62)  c = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) c = 8'h2b;
    else                 c = 8'h2f;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vto_front.sv =====
// Front end: config registers, request classification and raw token build.
`default_nettype none

module vto_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vto_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vto_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                       kind_i,
  input  logic [31:0]                      timestamp_i,
  output logic                             tok_valid_o,
  output vto_pkg::token_t                  tok_o
);
  import vto_pkg::*;

  logic [63:0] ver_lo_q, ver_hi_q, key_lo_q, win0_q, win1_q;
  logic [31:0] key_hi_q, win2_q;

  byte_t ver    [VER_BYTES];
  byte_t win    [TOKEN_RAW];
  byte_t fkey   [KEY_BYTES];
  byte_t hkey   [HEX_LEN];
  byte_t client [TOKEN_RAW];
  byte_t src    [TOKEN_RAW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_lo_q <= '0;
      ver_hi_q <= '0;
      key_lo_q <= '0;
      key_hi_q <= '0;
      win0_q   <= '0;
      win1_q   <= '0;
      win2_q   <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_VERSION_LOW:  ver_lo_q <= cfg_wdata_i;
        REG_VERSION_HIGH: ver_hi_q <= cfg_wdata_i;
        REG_KEY_LOW:      key_lo_q <= cfg_wdata_i;
        REG_KEY_HIGH:     key_hi_q <= cfg_wdata_i[31:0];
        REG_WINVER_WORD0: win0_q   <= cfg_wdata_i;
        REG_WINVER_WORD1: win1_q   <= cfg_wdata_i;
        REG_WINVER_WORD2: win2_q   <= cfg_wdata_i[31:0];
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  // Both XOR passes collapse into one effective key byte per position.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ver[i]     = ver_lo_q[8*i +: 8];
      ver[8+i]   = ver_hi_q[8*i +: 8];
      fkey[i]    = key_lo_q[8*i +: 8];
      win[i]     = win0_q[8*i +: 8];
      win[8+i]   = win1_q[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      fkey[8+i]  = key_hi_q[8*i +: 8];
      win[16+i]  = win2_q[8*i +: 8];
    end
    for (int i = 0; i < HEX_LEN; i++) begin
      hkey[i] = hex_char(timestamp_i[4*(HEX_LEN-1-i) +: 4]);
    end
    for (int j = 0; j < VER_BYTES; j++) begin
      client[j] = ver[j] ^ hkey[j % HEX_LEN] ^ hkey[(VER_BYTES-1-j) % HEX_LEN];
    end
    for (int i = 0; i < TS_BYTES; i++) begin
      client[VER_BYTES+i] = timestamp_i[8*(TS_BYTES-1-i) +: 8];  // big-endian
    end

    tok_valid_o = 1'b1;
    tok_o.b64   = 1'b0;
    src         = client;
    case (kind_e'(kind_i))
      KIND_B64: tok_o.b64 = 1'b1;
      KIND_RAW: tok_o.b64 = 1'b0;
      KIND_WIN: src = win;
      default:  tok_valid_o = 1'b0;  // unused kind: no token
    endcase

    for (int j = 0; j < TOKEN_RAW; j++) begin
      tok_o.raw[j] = src[j] ^ fkey[j % KEY_LEN] ^ fkey[(TOKEN_RAW-1-j) % KEY_LEN];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vto_queue.sv =====
// Two-entry token queue between front and back end.
`default_nettype none

module vto_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vto_pkg::token_t din_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output vto_pkg::token_t dout_o
);
  import vto_pkg::*;

  token_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= din_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("token queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("token queue underflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("token queue count out of range");

endmodule

`default_nettype wire

// ===== hdl/vto_back.sv =====
// Back end: serializes one token per request, raw bytes or base64 characters.
`default_nettype none

module vto_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  vto_pkg::token_t q_tok_i,
  output logic            q_pop_o,
  output logic            out_strobe_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import vto_pkg::*;

  token_t           cur_q;
  logic             active_q, active_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             strobe_q, last_q;
  byte_t            byte_q, char_d;
  logic             at_end, load;
  logic [GRP_W-1:0] grp;
  byte_t            a, b, c, raw_byte, b64_byte;

  assign at_end  = (pos_q == (cur_q.b64 ? POS_W'(TOKEN_B64-1) : POS_W'(TOKEN_RAW-1)));
  assign load    = q_valid_i && (!active_q || at_end);
  assign q_pop_o = load;

  always_comb begin
    active_d = active_q && !at_end;
    pos_d    = active_q ? pos_q + 1'b1 : pos_q;
    if (load) begin
      active_d = 1'b1;
      pos_d    = '0;
    end
  end

  // Character for the current position.
  always_comb begin
    grp = pos_q[POS_W-1:2];
    a   = '0;
    b   = '0;
    c   = '0;
    for (int g = 0; g < B64_GROUPS; g++) begin
      if (grp == GRP_W'(g)) begin
        a = cur_q.raw[3*g];
        b = cur_q.raw[3*g+1];
        c = cur_q.raw[3*g+2];
      end
    end
    if (grp == GRP_W'(B64_GROUPS)) begin  // trailing two-byte group
      a = cur_q.raw[TOKEN_RAW-2];
      b = cur_q.raw[TOKEN_RAW-1];
    end
    case (pos_q[1:0])
      2'd0:    b64_byte = b64_char(a[7:2]);
      2'd1:    b64_byte = b64_char({a[1:0], b[7:4]});
      2'd2:    b64_byte = b64_char({b[3:0], c[7:6]});
      default: b64_byte = b64_char(c[5:0]);
    endcase
    if (pos_q == POS_W'(TOKEN_B64-1)) b64_byte = B64_PAD;
    raw_byte = (pos_q < POS_W'(TOKEN_RAW)) ? cur_q.raw[pos_q] : '0;
    char_d   = cur_q.b64 ? b64_byte : raw_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      strobe_q <= active_q;
      last_q   <= active_q && at_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load)     cur_q  <= q_tok_i;
    if (active_q) byte_q <= char_d;
  end

  assign out_strobe_o = strobe_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;

  a_pos_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !cur_q.b64) |-> (pos_q <= POS_W'(TOKEN_RAW-1)))
    else $error("raw token position past end");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && at_end) |=> (last_o && out_strobe_o))
    else $error("final byte not flagged");

endmodule

`default_nettype wire

// ===== hdl/version_token_obfuscator_core.sv =====
// Top level of the version token obfuscator: front end, token queue, back end.
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries kind_i (0 base64 client token, 1 raw client token, 2 raw windows
//   token, 3 nothing) and timestamp_i, the key source for client tokens.
//   The front end builds the 20 raw token bytes in the accepting cycle and
//   pushes them into a two-entry queue; kind 3 is accepted and dropped.
//   The back end pops one token at a time and sends it one byte per cycle on
//   out_byte_o, marked by out_strobe_o; last_o flags the final byte.
//   The first byte goes from the queue through the back end's token register
//   and output byte register to the ports (held for one cycle).
//   A token is sent as 20 raw bytes or 28 base64 characters by the
//   one-byte-per-cycle back end. Queued tokens follow each other with no gap.
//   busy is high while the queue holds two tokens waiting.
//   The receiver cannot stall: every strobed byte must be taken.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0..6:
//   version low/high, key low/high, windows words 0..2); other indexes are
//   ignored. Writes must come only while no token is in flight (not enforced).
//   Reset clears all config registers, the queue and the back end.
`default_nettype none

module version_token_obfuscator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind_i,
  input  logic [31:0]                     timestamp_i,
  input  logic                            cfg_we_i,
  input  logic [vto_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vto_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                            out_strobe_o,
  output logic [7:0]                      out_byte_o,
  output logic                            last_o
);
  import vto_pkg::*;

  logic   tok_valid, push, q_full, q_valid, q_pop;
  token_t tok, q_tok;

  // Request accepted whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full && tok_valid;

  vto_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .timestamp_i (timestamp_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  vto_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (tok),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .dout_o  (q_tok)
  );

  vto_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_tok_i      (q_tok),
    .q_pop_o      (q_pop),
    .out_strobe_o (out_strobe_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/vto_token_checker.sv =====
// Watches the version token obfuscator ports, predicts each token and checks every byte.
`timescale 1ns / 1ps

module vto_token_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [1:0]                      kind_i,
  input  logic [31:0]                     timestamp_i,
  input  logic                            cfg_we_i,
  input  logic [vto_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vto_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            out_strobe_i,
  input  logic [7:0]                      out_byte_i,
  input  logic                            last_i,
  output int                              errors_o,
  output int                              pending_o
);
  import vto_pkg::*;

  typedef logic [TOKEN_RAW-1:0][7:0] raw_tok_t;  // [0] is byte 0
  typedef logic [KEY_BYTES-1:0][7:0] key_bytes_t;

  typedef struct {
    byte_t data;
    logic  last;
  } tok_byte_t;

  // shadow copies of the config registers
  logic [63:0] version_lo, version_hi, key_lo, winver0, winver1;
  logic [31:0] key_hi, winver2;

  tok_byte_t token_bytes_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: token mismatch: %s", $time, msg);
    errors_o = errors_o + 1;
  endtask

  function automatic byte_t hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? ("0" + {4'h0, nib}) : ("a" + {4'h0, nib} - 8'd10);
  endfunction

  function automatic byte_t b64_symbol(input logic [5:0] v);
    if (v < 6'd26) return "A" + {2'b00, v};
    if (v < 6'd52) return "a" + {2'b00, v} - 8'd26;
    if (v < 6'd62) return "0" + {2'b00, v} - 8'd52;
    return (v == 6'd62) ? "+" : "/";
  endfunction

  // key run forward over the first len bytes, then again from the tail back
  function automatic raw_tok_t xor_twice(input raw_tok_t d, input int len,
                                         input key_bytes_t k, input int klen);
    raw_tok_t r;
    r = d;
    for (int i = 0; i < len; i++) r[i] = r[i] ^ k[i % klen];
    for (int i = 0; i < len; i++) r[len-1-i] = r[len-1-i] ^ k[i % klen];
    return r;
  endfunction

  function automatic void predict_token(input logic [1:0] kind, input logic [31:0] ts);
    raw_tok_t   tok;
    key_bytes_t hkey, fkey;
    byte_t      chars [0:TOKEN_B64-1];
    int         klen, n, o;
    tok  = '0;
    hkey = '0;
    klen = KEY_LEN;
    if (klen < 1) klen = 1;
    if (klen > KEY_BYTES) klen = KEY_BYTES;
    for (int i = 0; i < 8; i++) fkey[i] = key_lo[8*i +: 8];
    for (int i = 0; i < 4; i++) fkey[8+i] = key_hi[8*i +: 8];

    case (kind)
      KIND_WIN: begin
        for (int i = 0; i < 8; i++) begin
          tok[i]   = winver0[8*i +: 8];
          tok[8+i] = winver1[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) tok[16+i] = winver2[8*i +: 8];
      end
      KIND_B64, KIND_RAW: begin
        for (int i = 0; i < HEX_LEN; i++) hkey[i] = hex_digit(ts[(7-i)*4 +: 4]);
        for (int i = 0; i < 8; i++) begin
          tok[i]   = version_lo[8*i +: 8];
          tok[8+i] = version_hi[8*i +: 8];
        end
        tok = xor_twice(tok, VER_BYTES, hkey, HEX_LEN);
        tok[16] = ts[31:24];
        tok[17] = ts[23:16];
        tok[18] = ts[15:8];
        tok[19] = ts[7:0];
      end
      default: return;  // unused kind: request dropped
    endcase
    tok = xor_twice(tok, TOKEN_RAW, fkey, klen);

    if (kind == KIND_B64) begin
      o = 0;
      for (int g = 0; g < 18; g += 3) begin
        chars[o]   = b64_symbol(tok[g][7:2]);
        chars[o+1] = b64_symbol({tok[g][1:0], tok[g+1][7:4]});
        chars[o+2] = b64_symbol({tok[g+1][3:0], tok[g+2][7:6]});
        chars[o+3] = b64_symbol(tok[g+2][5:0]);
        o += 4;
      end
      chars[24] = b64_symbol(tok[18][7:2]);
      chars[25] = b64_symbol({tok[18][1:0], tok[19][7:4]});
      chars[26] = b64_symbol({tok[19][3:0], 2'b00});
      chars[27] = B64_PAD;
      n = TOKEN_B64;
    end else begin
      for (int i = 0; i < TOKEN_RAW; i++) chars[i] = tok[i];
      n = TOKEN_RAW;
    end
    for (int i = 0; i < n; i++) token_bytes_q.push_back('{chars[i], i == n - 1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tok_byte_t exp_b;
    if (!rst_ni) begin
      version_lo = '0; version_hi = '0; key_lo = '0; key_hi = '0;
      winver0 = '0; winver1 = '0; winver2 = '0;
      token_bytes_q.delete();
      pending_o = 0;
    end else begin
      if (out_strobe_i !== 1'b0) begin
        if (out_strobe_i !== 1'b1) begin
          report_mismatch("strobe unknown");
        end else if (token_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b", out_byte_i, last_i));
        end else begin
          exp_b = token_bytes_q.pop_front();
          if (out_byte_i !== exp_b.data)
            report_mismatch($sformatf("byte %02h, want %02h", out_byte_i, exp_b.data));
          if (last_i !== exp_b.last)
            report_mismatch($sformatf("last %b, want %b", last_i, exp_b.last));
        end
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          REG_VERSION_LOW:  version_lo = cfg_wdata_i;
          REG_VERSION_HIGH: version_hi = cfg_wdata_i;
          REG_KEY_LOW:      key_lo     = cfg_wdata_i;
          REG_KEY_HIGH:     key_hi     = cfg_wdata_i[31:0];
          REG_WINVER_WORD0: winver0    = cfg_wdata_i;
          REG_WINVER_WORD1: winver1    = cfg_wdata_i;
          REG_WINVER_WORD2: winver2    = cfg_wdata_i[31:0];
          default: ;  // out-of-range index is ignored
        endcase
      end
      if (start_i === 1'b1 && busy_i === 1'b0) predict_token(kind_i, timestamp_i);
      pending_o = token_bytes_q.size();
    end
  end

  initial errors_o = 0;

endmodule

// ===== tb/tb_version_token_obfuscator_core.sv =====
// Stimulus and verdict for the version token obfuscator core.
`timescale 1ns / 1ps

module tb_version_token_obfuscator_core;
  import vto_pkg::*;

  // codes the package does not name
  localparam logic [1:0]           KIND_NONE  = 2'd3;  // accepted, no token
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // write must be ignored
  localparam int                   RAND_ITEMS = 25;    // requests per random phase

  typedef enum int {PLAN_ZERO, PLAN_ONES, PLAN_STRIPES, PLAN_RANDOM} plan_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            kind_i = KIND_B64;
  logic [31:0]           timestamp_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_VERSION_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  out_strobe_o;
  logic [7:0]            out_byte_o;
  logic                  last_o;
  int                    errors;
  int                    pending;

  logic [CFG_DATA_W-1:0] reg_plan [0:7];

  always #5 clk_i = ~clk_i;

  version_token_obfuscator_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .timestamp_i  (timestamp_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_o (out_strobe_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  vto_token_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .kind_i       (kind_i),
    .timestamp_i  (timestamp_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_i (out_strobe_o),
    .out_byte_i   (out_byte_o),
    .last_i       (last_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Idle gap before a request: none in a burst, else mostly none or short, now and then long
  // enough for the queue to run dry and the back end to go idle.
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called just after a rising edge. Holds start high until the request is
  // taken; busy is looked at on the falling edge so the read is race free.
  // Returns just after the accepting edge, with start still high.
  task automatic issue(input logic [1:0] kind, input logic [31:0] ts, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= kind;
    timestamp_i <= ts;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Let every token drain: drops start and waits until the checker expects
  // no further bytes.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void fill_plan(input plan_e plan);
    for (int i = REG_VERSION_LOW; i <= REG_WINVER_WORD2; i++) begin
      case (plan)
        PLAN_ZERO:    reg_plan[i] = '0;
        PLAN_ONES:    reg_plan[i] = '1;  // upper half dropped on 32-bit regs
        PLAN_STRIPES: reg_plan[i] = (i % 2 == 0) ? {16{4'h5}} : {16{4'ha}};
        default:      reg_plan[i] = {$urandom, $urandom};
      endcase
    end
    reg_plan[REG_UNUSED] = {$urandom, $urandom};
  endfunction

  // Writes every register, then the unused index, back to back.
  task automatic program_regs(input plan_e plan);
    fill_plan(plan);
    for (int i = REG_VERSION_LOW; i <= REG_UNUSED; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[CFG_IDX_W-1:0];
      cfg_wdata_i <= reg_plan[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input plan_e plan, input bit burst);
    logic [1:0]  kind;
    logic [31:0] ts;
    int          r;
    program_regs(plan);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 9);
      if (r < 3)      kind = KIND_B64;
      else if (r < 6) kind = KIND_RAW;
      else if (r < 9) kind = KIND_WIN;
      else            kind = KIND_NONE;
      r = $urandom_range(0, 9);
      if (r == 0)      ts = '0;
      else if (r == 1) ts = '1;
      else             ts = $urandom;
      issue(kind, ts, pick_gap(burst));
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers as left by reset; timestamp all digits, then all letters.
    issue(KIND_B64, 32'h0000_0000, 0);
    issue(KIND_RAW, 32'hffff_ffff, 0);
    issue(KIND_WIN, $urandom, 0);
    issue(KIND_NONE, $urandom, 0);
    drain();

    // All ones everywhere, wide writes to the 32-bit registers, index 7 junk.
    program_regs(PLAN_ONES);
    issue(KIND_B64, 32'hffff_ffff, 2);
    issue(KIND_RAW, 32'h0000_0000, 0);
    issue(KIND_WIN, 32'h0000_0000, 0);
    issue(KIND_NONE, 32'hffff_ffff, 0);
    issue(KIND_B64, 32'h9a9a_9a9a, 0);  // digit/letter boundary nibbles
    drain();

    program_regs(PLAN_STRIPES);
    issue(KIND_B64, 32'h0123_abcd, 0);
    issue(KIND_RAW, 32'hfedc_5432, 0);
    issue(KIND_WIN, $urandom, 0);
    drain();

    // random phases, one of them with no idle cycles at all
    random_phase(PLAN_RANDOM, 1'b0);
    random_phase(PLAN_STRIPES, 1'b1);
    random_phase(PLAN_RANDOM, 1'b0);
    random_phase(PLAN_RANDOM, 1'b0);

    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
